>>> hdl/sbsd_pkg.sv
// Shared constants, codes and helpers for the SBUS stick and switch decoder.
`default_nettype none

package sbsd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN  = 25;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FLAG_BYTE  = 23;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_LEN + 1);

    // Field widths
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CH_W   = 11;
    localparam int unsigned Q_W    = 16;
    localparam int unsigned DZ_W   = 15;
    localparam int unsigned TMO_W  = 32;
    localparam int unsigned SW_W   = 2;
    localparam int unsigned IDX_W  = 1;
    localparam int unsigned CFG_W  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DEAD_ZONE = 1'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT   = 1'd1;

    // Register reset values
    localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = 15'd164;
    localparam logic [TMO_W-1:0] TIMEOUT_RST   = 32'd100;

    // Stick scaling: q = trunc((v - 1024) * 16384 / 660) = trunc((v - 1024) * 4096 / 165).
    // Magnitude is scaled by a reciprocal, exact for magnitudes up to 1024.
    localparam int unsigned STICK_MID   = 1024;
    localparam int unsigned Q_ONE       = 16384;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned PROD_W      = CH_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd4096 << RECIP_SHIFT) + 64'd164) / 64'd165);

    // Switch positions
    localparam logic [SW_W-1:0] SW_DOWN = 2'd0;
    localparam logic [SW_W-1:0] SW_MID  = 2'd1;
    localparam logic [SW_W-1:0] SW_UP   = 2'd2;
    localparam logic [SW_W-1:0] SW_ERR  = 2'd3;
    localparam logic [CH_W-1:0] SW_LOW_LIM  = 11'd694;
    localparam logic [CH_W-1:0] SW_HIGH_LIM = 11'd1354;

    function automatic logic [SW_W-1:0] switch_pos(input logic [CH_W-1:0] raw);
        logic [SW_W-1:0] pos;
        if (raw < SW_LOW_LIM) begin
            pos = SW_DOWN;
        end else if (raw < SW_HIGH_LIM) begin
            pos = SW_MID;
        end else begin
            pos = SW_UP;
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sbsd_if.sv
// Channel interfaces of the decoder: input bytes and marks, decoded results, register writes.
`default_nettype none

interface sbsd_in_if;
    import sbsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sbsd_out_if;
    import sbsd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  connected;
    logic signed [Q_W-1:0] pitch;
    logic signed [Q_W-1:0] yaw;
    logic signed [Q_W-1:0] lateral;
    logic signed [Q_W-1:0] forward;
    logic [SW_W-1:0]       sw_left;
    logic [SW_W-1:0]       sw_right;

    modport source (output valid, output connected, output pitch, output yaw,
                    output lateral, output forward, output sw_left,
                    output sw_right, input ready);
    modport sink   (input valid, input connected, input pitch, input yaw,
                    input lateral, input forward, input sw_left,
                    input sw_right, output ready);
endinterface

interface sbsd_cfg_if;
    import sbsd_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/sbus_stick_switch_decoder_core.sv
// Top level of the SBUS stick and switch decoder.
//
//  channel  | dir | handshake            | carries
//  ---------+-----+----------------------+---------------------------------------
//  i_in     | in  | valid/ready          | command, data_byte
//  o_out    | out | valid/ready          | connected, four sticks, two switches
//  i_cfg    | in  | valid/ready (ready=1)| index, data (dead zone, timeout)
//
// Every input transaction is handled as it is taken: frame bytes land in the frame
// store, and the end of a full frame decodes it straight into the result register.
// A new transaction is taken each cycle while the result register is empty or being
// drained; a stalled result holds input ready low only while it is not taken.
// Sync active-low reset clears counters, link state, out valid and config to defaults.
`default_nettype none

module sbus_stick_switch_decoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbsd_in_if.sink    i_in,
    sbsd_out_if.source o_out,
    sbsd_cfg_if.sink   i_cfg
);
    import sbsd_pkg::*;

    // Configuration
    logic [DZ_W-1:0]   r_dead_zone;
    logic [TMO_W-1:0]  r_timeout;

    // Frame state
    logic [BYTE_W-1:0] r_store [FRAME_LEN];
    logic [CNT_W-1:0]  r_byte_count;
    logic [CNT_W-1:0]  n_byte_count;
    logic [TMO_W-1:0]  r_idle_ticks;
    logic [TMO_W-1:0]  n_idle_ticks;
    logic              r_linked;
    logic              n_linked;

    // Result register
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_out_connected;
    logic signed [Q_W-1:0] r_pitch;
    logic signed [Q_W-1:0] r_yaw;
    logic signed [Q_W-1:0] r_lateral;
    logic signed [Q_W-1:0] r_forward;
    logic [SW_W-1:0]   r_sw_left;
    logic [SW_W-1:0]   r_sw_right;

    logic              w_in_acc;
    logic              w_load;
    logic              w_good;
    logic [CH_W-1:0]   w_c1, w_c2, w_c3, w_c4, w_c6, w_c7;
    logic signed [Q_W-1:0] w_s1, w_s2, w_s3, w_s4;

    assign i_in.ready  = ~r_out_valid | o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid & i_in.ready;

    // Unpack the 11-bit channels from the stored frame
    assign w_c1 = {r_store[2][2:0], r_store[1]};
    assign w_c2 = {r_store[3][5:0], r_store[2][7:3]};
    assign w_c3 = {r_store[5][0],   r_store[4],   r_store[3][7:6]};
    assign w_c4 = {r_store[6][3:0], r_store[5][7:1]};
    assign w_c6 = {r_store[9][1:0], r_store[8],   r_store[7][7]};
    assign w_c7 = {r_store[10][4:0], r_store[9][7:2]};

    sbsd_stick u_stick_pitch   (.i_raw(w_c1), .i_dead_zone(r_dead_zone), .o_value(w_s1));
    sbsd_stick u_stick_yaw     (.i_raw(w_c2), .i_dead_zone(r_dead_zone), .o_value(w_s2));
    sbsd_stick u_stick_lateral (.i_raw(w_c3), .i_dead_zone(r_dead_zone), .o_value(w_s3));
    sbsd_stick u_stick_forward (.i_raw(w_c4), .i_dead_zone(r_dead_zone), .o_value(w_s4));

    // Decide next link state and whether a result is produced
    always_comb begin
        n_byte_count = r_byte_count;
        n_idle_ticks = r_idle_ticks;
        n_linked     = r_linked;
        w_load       = 1'b0;
        w_good       = 1'b0;
        if (w_in_acc) begin
            case (i_in.command)
                CMD_BYTE: begin
                    if (r_byte_count < CNT_OVER) begin
                        n_byte_count = r_byte_count + CNT_W'(1);
                    end
                end
                CMD_END: begin
                    n_byte_count = '0;
                    if (r_byte_count == CNT_FULL) begin
                        w_load = 1'b1;
                        if (r_store[FLAG_BYTE] != '0) begin
                            n_linked = 1'b0;
                        end else begin
                            w_good       = 1'b1;
                            n_linked     = 1'b1;
                            n_idle_ticks = '0;
                        end
                    end
                end
                CMD_TICK: begin
                    if (~&r_idle_ticks) begin
                        n_idle_ticks = r_idle_ticks + TMO_W'(1);
                    end
                    if (r_linked && (n_idle_ticks > r_timeout)) begin
                        n_linked = 1'b0;
                        w_load   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_valid = w_load | (r_out_valid & ~o_out.ready);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_idle_ticks <= '0;
            r_linked     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dead_zone  <= DEAD_ZONE_RST;
            r_timeout    <= TIMEOUT_RST;
        end else begin
            r_byte_count <= n_byte_count;
            r_idle_ticks <= n_idle_ticks;
            r_linked     <= n_linked;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_DEAD_ZONE: r_dead_zone <= i_cfg.data[DZ_W-1:0];
                    REG_TIMEOUT:   r_timeout   <= i_cfg.data[TMO_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture frame bytes, drop those past the end of the frame
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.command == CMD_BYTE) && (r_byte_count < CNT_FULL)) begin
            r_store[r_byte_count] <= i_in.data_byte;
        end
    end

    // Load the result register: decoded frame or the loss pattern
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_connected <= w_good;
            if (w_good) begin
                r_pitch    <= w_s1;
                r_yaw      <= -w_s2;
                r_lateral  <= -w_s3;
                r_forward  <= w_s4;
                r_sw_left  <= switch_pos(w_c6);
                r_sw_right <= switch_pos(w_c7);
            end else begin
                r_pitch    <= '0;
                r_yaw      <= '0;
                r_lateral  <= '0;
                r_forward  <= '0;
                r_sw_left  <= SW_ERR;
                r_sw_right <= SW_ERR;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.connected = r_out_connected;
    assign o_out.pitch     = r_pitch;
    assign o_out.yaw       = r_yaw;
    assign o_out.lateral   = r_lateral;
    assign o_out.forward   = r_forward;
    assign o_out.sw_left   = r_sw_left;
    assign o_out.sw_right  = r_sw_right;

    // Byte counter saturates just past a full frame
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_OVER)
        else $error("byte counter beyond saturation");

    // Losing the link always leaves a loss result in the output register
    a_loss_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_linked) && $past(i_rst_n) |-> r_out_valid && !r_out_connected)
        else $error("link dropped without a loss result");

    // A pending good result means the link is up
    a_good_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_connected |-> r_linked)
        else $error("connected result while link is down");

    // A loss result carries centred sticks and error switches
    a_loss_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_connected |->
            r_pitch == '0 && r_forward == '0 && r_sw_left == SW_ERR && r_sw_right == SW_ERR)
        else $error("loss result with live payload");

    // A full frame with clear flag byte brings the link up
    a_good_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.command == CMD_END && r_byte_count == CNT_FULL
            && r_store[FLAG_BYTE] == '0 |=> r_linked && r_out_valid && r_out_connected)
        else $error("good frame not decoded");

endmodule

`default_nettype wire

>>> hdl/sbsd_stick.sv
// One stick channel: centre, scale to Q1.14, clamp and apply the dead zone.
`default_nettype none

module sbsd_stick (
    input  wire logic [sbsd_pkg::CH_W-1:0]        i_raw,
    input  wire logic [sbsd_pkg::DZ_W-1:0]        i_dead_zone,
    output logic signed [sbsd_pkg::Q_W-1:0]       o_value
);
    import sbsd_pkg::*;

    logic              w_neg;
    logic [CH_W-1:0]   w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    w_qmag;
    logic [DZ_W-1:0]   w_clamped;
    logic [Q_W-1:0]    w_pos;

    // Centre on mid stick, keep sign and magnitude apart
    assign w_neg = i_raw < CH_W'(STICK_MID);
    assign w_mag = w_neg ? (CH_W'(STICK_MID) - i_raw) : (i_raw - CH_W'(STICK_MID));

    // Scale by 4096/165 through the reciprocal, truncating the magnitude
    assign w_prod = PROD_W'(w_mag) * PROD_W'(RECIP_K);
    assign w_qmag = w_prod[RECIP_SHIFT +: Q_W];

    // Clamp to one, then drop values inside the dead zone
    assign w_clamped = (w_qmag > Q_W'(Q_ONE)) ? DZ_W'(Q_ONE) : w_qmag[DZ_W-1:0];
    assign w_pos     = (w_clamped < i_dead_zone) ? '0 : Q_W'(w_clamped);

    // Restore the sign
    assign o_value = w_neg ? $signed(-w_pos) : $signed(w_pos);

endmodule

`default_nettype wire

>>> bench/tb_sbus_stick_switch_decoder_core.sv
// Self-checking testbench for the SBUS stick and switch decoder core.
module tb_sbus_stick_switch_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sbsd_pkg::*;

    // Command code with no meaning; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    // Stick scaling in Q1.14: centre, full scale and channel span to full scale
    localparam int STICK_CENTRE = 1024;
    localparam int STICK_FULL   = 16384;
    localparam int STICK_SPAN   = 660;

    localparam int unsigned NUM_CHANNELS = 16;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned PHASE_ITEMS  = 270;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                  connected;
        logic signed [Q_W-1:0] pitch;
        logic signed [Q_W-1:0] yaw;
        logic signed [Q_W-1:0] lateral;
        logic signed [Q_W-1:0] forward;
        logic [SW_W-1:0]       sw_left;
        logic [SW_W-1:0]       sw_right;
    } t_stick_result;

    // Decoder state mirror and the queue of stick results still owed by the block
    class stick_scoreboard;
        logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
        int unsigned       byte_cnt;
        logic [TMO_W-1:0]  idle_cnt;
        bit                link_up;
        logic [DZ_W-1:0]   dead_zone_reg;
        logic [TMO_W-1:0]  timeout_reg;
        t_stick_result     owed_q [$];
        int unsigned       failures;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            byte_cnt      = 0;
            idle_cnt      = '0;
            link_up       = 1'b0;
            dead_zone_reg = DEAD_ZONE_RST;
            timeout_reg   = TIMEOUT_RST;
            failures      = 0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_DEAD_ZONE) begin
                dead_zone_reg = data[DZ_W-1:0];
            end else if (idx == REG_TIMEOUT) begin
                timeout_reg = data[TMO_W-1:0];
            end
        endfunction

        // Scale, clamp and dead-zone one raw channel
        function int stick_q(logic [CH_W-1:0] raw);
            int centred;
            int q;
            int mag;
            centred = int'(raw) - STICK_CENTRE;
            q = (centred * STICK_FULL) / STICK_SPAN;
            if (q > STICK_FULL) q = STICK_FULL;
            if (q < -STICK_FULL) q = -STICK_FULL;
            mag = (q < 0) ? -q : q;
            if (mag < int'(dead_zone_reg)) q = 0;
            return q;
        endfunction

        function logic [SW_W-1:0] switch_code(logic [CH_W-1:0] raw);
            if (raw < SW_LOW_LIM) return SW_DOWN;
            if (raw < SW_HIGH_LIM) return SW_MID;
            return SW_UP;
        endfunction

        function t_stick_result link_lost();
            t_stick_result r;
            r = '0;
            r.sw_left  = SW_ERR;
            r.sw_right = SW_ERR;
            return r;
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
            t_stick_result           r;
            logic [22*BYTE_W-1:0]    bitstream;
            int unsigned             n;
            int unsigned             i;
            case (cmd)
                CMD_BYTE: begin
                    if (byte_cnt < FRAME_LEN) frame_bytes[byte_cnt] = b;
                    if (byte_cnt < FRAME_LEN + 1) byte_cnt++;
                end
                CMD_END: begin
                    n = byte_cnt;
                    byte_cnt = 0;
                    if (n == FRAME_LEN) begin
                        if (frame_bytes[FLAG_BYTE] != '0) begin
                            link_up = 1'b0;
                            owed_q.push_back(link_lost());
                        end else begin
                            // Channels are packed LSB first from byte 1 on
                            for (i = 1; i <= 22; i++) bitstream[8*(i-1) +: 8] = frame_bytes[i];
                            r.connected = 1'b1;
                            r.pitch     = Q_W'(stick_q(bitstream[0 +: CH_W]));
                            r.yaw       = Q_W'(-stick_q(bitstream[CH_W +: CH_W]));
                            r.lateral   = Q_W'(-stick_q(bitstream[2*CH_W +: CH_W]));
                            r.forward   = Q_W'(stick_q(bitstream[3*CH_W +: CH_W]));
                            r.sw_left   = switch_code(bitstream[5*CH_W +: CH_W]);
                            r.sw_right  = switch_code(bitstream[6*CH_W +: CH_W]);
                            link_up  = 1'b1;
                            idle_cnt = '0;
                            owed_q.push_back(r);
                        end
                    end
                end
                CMD_TICK: begin
                    if (idle_cnt != '1) idle_cnt++;
                    if (link_up && idle_cnt > timeout_reg) begin
                        link_up = 1'b0;
                        owed_q.push_back(link_lost());
                    end
                end
                default: ;
            endcase
        endfunction

        function string describe(t_stick_result r);
            return $sformatf("conn=%0b pitch=%0d yaw=%0d lat=%0d fwd=%0d swl=%0d swr=%0d",
                             r.connected, r.pitch, r.yaw, r.lateral, r.forward,
                             r.sw_left, r.sw_right);
        endfunction

        function void check_result(t_stick_result got);
            t_stick_result want;
            bit            ok;
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) $display("unexpected result: %s", describe(got));
                return;
            end
            want = owed_q.pop_front();
            ok = (got.connected === want.connected) && (got.pitch === want.pitch) &&
                 (got.yaw === want.yaw) && (got.lateral === want.lateral) &&
                 (got.forward === want.forward) &&
                 (got.sw_left === want.sw_left) &&
                 (got.sw_right === want.sw_right);
            if (!ok) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("result mismatch");
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          idle_on;
    int unsigned items_sent;
    int unsigned stall_left;
    int unsigned cycle_count;
    stick_scoreboard sb;

    sbsd_in_if  in_if ();
    sbsd_out_if out_if ();
    sbsd_cfg_if cfg_if ();

    sbus_stick_switch_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    // Gap length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Channel values biased to the centre, the clamp edges and the switch thresholds
    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 6))
            0: return ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd0;
            1: return CH_W'(STICK_CENTRE - 30 + $urandom_range(0, 60));
            2: return CH_W'(STICK_CENTRE - 700 + $urandom_range(0, 1400));
            3: begin
                case ($urandom_range(0, 3))
                    0: return 11'd363;
                    1: return 11'd364;
                    2: return 11'd1684;
                    default: return 11'd1685;
                endcase
            end
            4: return ($urandom_range(0, 1) != 0) ? CH_W'(SW_LOW_LIM - $urandom_range(0, 1))
                                                  : CH_W'(SW_HIGH_LIM - $urandom_range(0, 1));
            default: return CH_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Output side: hold ready low for random stretches
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    function automatic t_stick_result captured_result();
        t_stick_result r;
        r.connected = out_if.connected;
        r.pitch     = out_if.pitch;
        r.yaw       = out_if.yaw;
        r.lateral   = out_if.lateral;
        r.forward   = out_if.forward;
        r.sw_left   = out_if.sw_left;
        r.sw_right  = out_if.sw_right;
        return r;
    endfunction

    // Observe every transaction at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_result(captured_result());
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
                sb.note_input(in_if.command, in_if.data_byte);
            if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
                sb.write_reg(cfg_if.index, cfg_if.data);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sbus_stick_switch_decoder_core regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] dbyte);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.data_byte <= dbyte;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (cmd != CMD_NONE) items_sent++;
    endtask

    task automatic send_junk(int unsigned count);
        repeat (count) send_item(CMD_BYTE, 8'($urandom));
    endtask

    // Pack the given channels (others random) into a 25-byte frame and close it
    task automatic send_sbus_frame(input logic [CH_W-1:0] c1, c2, c3, c4, c6, c7,
                                   input logic [BYTE_W-1:0] flags);
        logic [CH_W-1:0]           chans [NUM_CHANNELS];
        logic [NUM_CHANNELS*CH_W-1:0] bitstream;
        logic [BYTE_W-1:0]         fbytes [FRAME_LEN];
        int unsigned               k;
        for (k = 0; k < NUM_CHANNELS; k++) chans[k] = CH_W'($urandom_range(0, 2047));
        chans[0] = c1;
        chans[1] = c2;
        chans[2] = c3;
        chans[3] = c4;
        chans[5] = c6;
        chans[6] = c7;
        for (k = 0; k < NUM_CHANNELS; k++) bitstream[k*CH_W +: CH_W] = chans[k];
        fbytes[0] = 8'($urandom);
        for (k = 1; k <= 22; k++) fbytes[k] = bitstream[8*(k-1) +: 8];
        fbytes[FLAG_BYTE] = flags;
        fbytes[24] = 8'($urandom);
        for (k = 0; k < FRAME_LEN; k++) send_item(CMD_BYTE, fbytes[k]);
        send_item(CMD_END, 8'($urandom));
    endtask

    // Stop sending and let every owed result drain, then let the block settle
    task automatic pause_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed frames, with ticks, bad lengths and stray transactions mixed in
    task automatic run_random(int unsigned count);
        int unsigned       stop_at;
        int unsigned       r;
        int unsigned       n;
        logic [BYTE_W-1:0] flags;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                flags = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_sbus_frame(pick_channel(), pick_channel(), pick_channel(),
                                pick_channel(), pick_channel(), pick_channel(), flags);
                repeat ($urandom_range(0, 2)) send_item(CMD_TICK, 8'($urandom));
            end else if (r < 80) begin
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 6);
                repeat (n) send_item(CMD_TICK, 8'($urandom));
            end else if (r < 87) begin
                send_junk($urandom_range(0, 24));
                send_item(CMD_END, 8'($urandom));
            end else if (r < 92) begin
                send_junk($urandom_range(26, 40));
                send_item(CMD_END, 8'($urandom));
            end else if (r < 95) begin
                repeat ($urandom_range(1, 3)) send_item(CMD_NONE, 8'($urandom));
            end else if (r < 98) begin
                send_item(CMD_END, 8'($urandom));
            end else begin
                send_junk($urandom_range(1, 5));
            end
            if ($urandom_range(0, 99) < 3) pause_until_drained();
        end
    endtask

    initial begin
        int unsigned       ph;
        logic [DZ_W-1:0]   dz;
        logic [TMO_W-1:0]  tmo;

        in_if.valid     = 1'b0;
        in_if.command   = CMD_BYTE;
        in_if.data_byte = '0;
        out_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_DEAD_ZONE;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        idle_on         = 1'b1;
        items_sent      = 0;
        stall_left      = 0;
        cycle_count     = 0;
        sb = new();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset register values, stick extremes, dead zone, switch thresholds
        send_sbus_frame(11'd0, 11'd2047, 11'd1024, 11'd1030, 11'd693, 11'd694, 8'h00);
        pause_until_drained();
        send_sbus_frame(11'd2047, 11'd0, 11'd1684, 11'd363, 11'd1353, 11'd1354, 8'h00);
        // Nonzero flag byte drops the link
        send_sbus_frame(11'd1031, 11'd1017, 11'd1500, 11'd500, 11'd0, 11'd2047, 8'h0C);
        // Unused command, one byte short, overlong frame, empty frame
        send_item(CMD_NONE, 8'hFF);
        send_junk(FRAME_LEN - 1);
        send_item(CMD_END, 8'h00);
        send_junk(40);
        send_item(CMD_END, 8'hFF);
        send_item(CMD_END, 8'h00);

        // Random phases over several register settings
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    dz  = '0;
                    tmo = 32'd1;
                end
                1: begin
                    dz  = DZ_W'(STICK_FULL);
                    tmo = '1;
                end
                2: begin
                    dz  = DEAD_ZONE_RST;
                    tmo = TIMEOUT_RST;
                end
                3: begin
                    dz  = DZ_W'($urandom_range(0, 2000));
                    tmo = TMO_W'($urandom_range(2, 12));
                end
                default: begin
                    dz  = DZ_W'($urandom_range(0, STICK_FULL));
                    tmo = TMO_W'($urandom_range(1, 60));
                end
            endcase
            idle_on = (ph != 2);
            pause_until_drained();
            cfg_write(REG_DEAD_ZONE, CFG_W'(dz));
            cfg_write(REG_TIMEOUT, CFG_W'(tmo));
            run_random(PHASE_ITEMS);
        end

        pause_until_drained();
        repeat (2 * SETTLE) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("sbus_stick_switch_decoder_core regression: pass");
        end else begin
            $display("sbus_stick_switch_decoder_core regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/sbsd_pkg.sv
hdl/sbsd_if.sv
hdl/sbsd_stick.sv
hdl/sbus_stick_switch_decoder_core.sv
bench/tb_sbus_stick_switch_decoder_core.sv
